>>> rtl/apdu_lrc_pkg.sv
package apdu_lrc_pkg;

	// action codes of an input request
	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_CMD_BYTE = 2'd1;
	localparam logic [1:0] ACT_RX_BYTE = 2'd2;
	localparam logic [1:0] ACT_TICK = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_TX = 2'd0;
	localparam logic [1:0] KIND_RX_DATA = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// final status codes
	localparam logic [2:0] ST_NONE = 3'd0;
	localparam logic [2:0] ST_OK = 3'd1;
	localparam logic [2:0] ST_OTHER_SW = 3'd2;
	localparam logic [2:0] ST_LRC_ERR = 3'd3;
	localparam logic [2:0] ST_TIMEOUT = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;
	localparam logic [2:0] ST_BUSY = 3'd6;

	localparam logic [7:0] SYNC_BYTE = 8'h55;
	localparam logic [15:0] SW_SUCCESS = 16'h9000;
	localparam logic [15:0] TIMEOUT_RESET = 16'd300;
	localparam int TX_OVERHEAD = 8;
	localparam int RX_OVERHEAD = 6;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TXDATA,
		PH_HUNT,
		PH_HEAD,
		PH_RXDATA,
		PH_LRC
	} phase_t;

	typedef struct packed {
		logic [1:0] action;
		logic [31:0] command_header;
		logic [10:0] data_length;
		logic [7:0] byte_value;
	} item_t;

	// all results caused by one request; they share kind, status and status word
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0][7:0] bytes;
		logic [2:0] last_idx;
		logic [2:0] status;
		logic [15:0] sw;
	} burst_t;

endpackage

>>> rtl/apdu_lrc_core.sv
module apdu_lrc_core #(
	parameter int TX_BUFFER_BYTES = 2048,
	parameter int RX_BUFFER_BYTES = 2048
) (
	input logic clk,
	input logic arst_n,
	input logic go,
	input apdu_lrc_pkg::item_t item,
	input logic [15:0] timeout_ticks,
	output logic res_valid,
	output apdu_lrc_pkg::burst_t res
);
	import apdu_lrc_pkg::*;

	localparam logic [17:0] TX_LIMIT = 18'(TX_BUFFER_BYTES);
	localparam logic [17:0] RX_LIMIT = 18'(RX_BUFFER_BYTES);
	localparam logic [17:0] TX_OVH = 18'(TX_OVERHEAD);
	localparam logic [17:0] RX_OVH = 18'(RX_OVERHEAD);

	phase_t phase_q, phase_d;
	logic [10:0] tx_rem_q, tx_rem_d;
	logic [7:0] acc_q, acc_d;
	logic [2:0] rx_cnt_q, rx_cnt_d;
	logic [15:0] rlen_q, rlen_d;
	logic [15:0] rsw_q, rsw_d;
	logic [15:0] tleft_q, tleft_d;

	logic [7:0] hdr_xor;
	logic [7:0] len_hi;
	logic [15:0] new_rlen;
	logic [17:0] tx_need;
	logic [17:0] rx_need;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tx_rem_q <= '0;
			acc_q <= '0;
			rx_cnt_q <= '0;
			rlen_q <= '0;
			rsw_q <= '0;
			tleft_q <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			tx_rem_q <= tx_rem_d;
			acc_q <= acc_d;
			rx_cnt_q <= rx_cnt_d;
			rlen_q <= rlen_d;
			rsw_q <= rsw_d;
			tleft_q <= tleft_d;
		end
	end

	assign len_hi = {5'd0, item.data_length[10:8]};
	assign hdr_xor = item.command_header[31:24] ^ item.command_header[23:16]
		^ item.command_header[15:8] ^ item.command_header[7:0]
		^ len_hi ^ item.data_length[7:0];
	assign tx_need = {7'd0, item.data_length} + TX_OVH;
	assign new_rlen = {rlen_q[15:8], item.byte_value};
	assign rx_need = {2'd0, new_rlen} + RX_OVH;

	always_comb begin
		phase_d = phase_q;
		tx_rem_d = tx_rem_q;
		acc_d = acc_q;
		rx_cnt_d = rx_cnt_q;
		rlen_d = rlen_q;
		rsw_d = rsw_q;
		tleft_d = tleft_q;
		res_valid = 1'b0;
		res.kind = KIND_TX;
		res.bytes = '0;
		res.last_idx = '0;
		res.status = ST_NONE;
		res.sw = '0;

		case (item.action)
			ACT_START: begin
				res_valid = 1'b1;
				if (phase_q != PH_IDLE) begin
					res.kind = KIND_STATUS;
					res.status = ST_BUSY;
				end else if (tx_need > TX_LIMIT) begin
					res.kind = KIND_STATUS;
					res.status = ST_OVERFLOW;
				end else begin
					rsw_d = '0;
					rlen_d = '0;
					rx_cnt_d = '0;
					acc_d = hdr_xor;
					tx_rem_d = item.data_length;
					res.bytes[0] = SYNC_BYTE;
					res.bytes[1] = item.command_header[31:24];
					res.bytes[2] = item.command_header[23:16];
					res.bytes[3] = item.command_header[15:8];
					res.bytes[4] = item.command_header[7:0];
					res.bytes[5] = len_hi;
					res.bytes[6] = item.data_length[7:0];
					// no data to follow: close the frame right away
					if (item.data_length == '0) begin
						res.bytes[7] = ~hdr_xor;
						res.last_idx = 3'd7;
						phase_d = PH_HUNT;
						tleft_d = timeout_ticks;
					end else begin
						res.last_idx = 3'd6;
						phase_d = PH_TXDATA;
					end
				end
			end
			ACT_CMD_BYTE: begin
				if (phase_q == PH_TXDATA) begin
					res_valid = 1'b1;
					acc_d = acc_q ^ item.byte_value;
					tx_rem_d = tx_rem_q - 11'd1;
					res.bytes[0] = item.byte_value;
					if (tx_rem_q == 11'd1) begin
						res.bytes[1] = ~(acc_q ^ item.byte_value);
						res.last_idx = 3'd1;
						phase_d = PH_HUNT;
						tleft_d = timeout_ticks;
					end
				end
			end
			ACT_RX_BYTE: begin
				case (phase_q)
					PH_HUNT: begin
						if (item.byte_value == SYNC_BYTE) begin
							phase_d = PH_HEAD;
							rx_cnt_d = 3'd1;
							acc_d = '0;
						end
					end
					PH_HEAD: begin
						acc_d = acc_q ^ item.byte_value;
						rx_cnt_d = rx_cnt_q + 3'd1;
						if (rx_cnt_q == 3'd1) begin
							rsw_d = {item.byte_value, 8'd0};
						end else if (rx_cnt_q == 3'd2) begin
							rsw_d = {rsw_q[15:8], item.byte_value};
						end else if (rx_cnt_q == 3'd3) begin
							rlen_d = {item.byte_value, 8'd0};
						end else begin
							rlen_d = new_rlen;
							if (rx_need > RX_LIMIT) begin
								res_valid = 1'b1;
								res.kind = KIND_STATUS;
								res.status = ST_OVERFLOW;
								phase_d = PH_IDLE;
							end else if (new_rlen == '0) begin
								phase_d = PH_LRC;
							end else begin
								phase_d = PH_RXDATA;
							end
						end
					end
					PH_RXDATA: begin
						res_valid = 1'b1;
						res.kind = KIND_RX_DATA;
						res.bytes[0] = item.byte_value;
						acc_d = acc_q ^ item.byte_value;
						rlen_d = rlen_q - 16'd1;
						if (rlen_q == 16'd1) begin
							phase_d = PH_LRC;
						end
					end
					PH_LRC: begin
						res_valid = 1'b1;
						res.kind = KIND_STATUS;
						res.sw = rsw_q;
						if (item.byte_value != ~acc_q) begin
							res.status = ST_LRC_ERR;
						end else if (rsw_q == SW_SUCCESS) begin
							res.status = ST_OK;
						end else begin
							res.status = ST_OTHER_SW;
						end
						phase_d = PH_IDLE;
					end
					default: begin
					end
				endcase
			end
			ACT_TICK: begin
				if (phase_q == PH_HUNT) begin
					if (tleft_q != '0) begin
						tleft_d = tleft_q - 16'd1;
					end
					if (tleft_q <= 16'd1) begin
						res_valid = 1'b1;
						res.kind = KIND_STATUS;
						res.status = ST_TIMEOUT;
						phase_d = PH_IDLE;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/apdu_lrc_ser.sv
module apdu_lrc_ser (
	input logic clk,
	input logic arst_n,
	input logic load,
	input apdu_lrc_pkg::burst_t burst,
	output logic free,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic last,
	output logic [2:0] status,
	output logic [15:0] status_word
);
	import apdu_lrc_pkg::*;

	burst_t burst_s2;
	logic valid_q;
	logic [2:0] idx_q;
	logic take;

	assign take = valid_q && !out_stall;
	assign last = (idx_q == burst_s2.last_idx);
	assign free = !valid_q || (take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (free) begin
			valid_q <= load;
			idx_q <= '0;
		end else if (take) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			burst_s2 <= burst;
		end
	end

	assign out_valid = valid_q;
	assign kind = burst_s2.kind;
	assign out_byte = burst_s2.bytes[idx_q];
	assign status = burst_s2.status;
	assign status_word = burst_s2.sw;

endmodule

>>> rtl/apdu_frame_lrc_exchange_top.sv
// Framed command/reply exchange with a security chip. A start request emits the
// frame head (0x55, CLA, INS, P1, P2, Len1, Len2), each command data request emits
// its byte, and the last one is followed by LRC1; the reply is then hunted for 0x55
// with a tick timeout, its header captured, its data bytes passed on, and LRC2
// checked into one final status. A request is registered on entry and settled
// into a result register that delivers one result per cycle unless out_stall is
// high: requests that cause at most one result flow at one per cycle, an accepted
// start gives seven or eight results and a closing data byte two, in turn at the
// single output port; no-result requests also wait for it. The user must write
// the timeout register through the cfg port while the block is idle; not enforced.
module apdu_frame_lrc_exchange_top #(
	parameter int TX_BUFFER_BYTES = 2048,
	parameter int RX_BUFFER_BYTES = 2048
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] action,
	input logic [31:0] command_header,
	input logic [10:0] data_length,
	input logic [7:0] byte_value,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic last,
	output logic [2:0] status,
	output logic [15:0] status_word,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [15:0] cfg_data
);
	import apdu_lrc_pkg::*;

	item_t item_s1;
	logic valid_s1;
	logic [15:0] timeout_ticks_q;
	logic free;
	logic go;
	logic res_valid;
	burst_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q <= TIMEOUT_RESET;
		end else if (cfg_valid) begin
			timeout_ticks_q <= cfg_data;
		end
	end

	// hold the registered request until the result register can take it
	assign in_stall = valid_s1 && !free;
	assign go = valid_s1 && free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.action <= action;
			item_s1.command_header <= command_header;
			item_s1.data_length <= data_length;
			item_s1.byte_value <= byte_value;
		end
	end

	apdu_lrc_core #(
		.TX_BUFFER_BYTES(TX_BUFFER_BYTES),
		.RX_BUFFER_BYTES(RX_BUFFER_BYTES)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.go(go),
		.item(item_s1),
		.timeout_ticks(timeout_ticks_q),
		.res_valid(res_valid),
		.res(res)
	);

	apdu_lrc_ser u_ser (
		.clk(clk),
		.arst_n(arst_n),
		.load(go && res_valid),
		.burst(res),
		.free(free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.out_byte(out_byte),
		.last(last),
		.status(status),
		.status_word(status_word)
	);

endmodule

>>> bench/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import apdu_lrc_pkg::*;

	localparam int TX_BYTES = 2048;
	localparam int RX_BYTES = 2048;
	localparam int DRAIN_SLACK = 10;
	localparam int HOLD_CYCLES = 300;
	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic last;
		logic [2:0] status;
		logic [15:0] sw;
	} frame_result_t;

	class exchange_scoreboard;
		phase_t ph;
		logic [10:0] tx_left;
		logic [7:0] lrc;
		logic [11:0] rx_cnt;
		logic [15:0] rlen;
		logic [15:0] rsw;
		logic [15:0] ticks_left;
		logic [15:0] reply_timeout;
		frame_result_t awaited[$];
		int errors;
		int checked;
		int finals;

		function new();
			ph = PH_IDLE;
			tx_left = '0;
			lrc = '0;
			rx_cnt = '0;
			rlen = '0;
			rsw = '0;
			ticks_left = '0;
			reply_timeout = TIMEOUT_RESET;
			errors = 0;
			checked = 0;
			finals = 0;
		endfunction

		function void push(logic [1:0] k, logic [7:0] b, logic [2:0] st, logic [15:0] sw);
			awaited.push_back({k, b, 1'b0, st, sw});
		endfunction

		function void push_tx(logic [7:0] b);
			push(KIND_TX, b, ST_NONE, 16'h0000);
			lrc ^= b;
		endfunction

		function void close_command();
			push(KIND_TX, ~lrc, ST_NONE, 16'h0000);
			ph = PH_HUNT;
			ticks_left = reply_timeout;
		endfunction

		// returns 1 when the request caused a result or moved the state
		function bit note_request(item_t rq);
			logic [81:0] was;
			int n0;
			int i;
			frame_result_t tail;
			logic [7:0] b;
			logic [2:0] st;
			was = {ph, tx_left, lrc, rx_cnt, rlen, rsw, ticks_left};
			n0 = awaited.size();
			b = rq.byte_value;
			case (rq.action)
				ACT_START: begin
					if (ph != PH_IDLE) begin
						push(KIND_STATUS, 8'h00, ST_BUSY, 16'h0000);
					end else if (int'(rq.data_length) + TX_OVERHEAD > TX_BYTES) begin
						push(KIND_STATUS, 8'h00, ST_OVERFLOW, 16'h0000);
					end else begin
						lrc = '0;
						rsw = '0;
						rlen = '0;
						rx_cnt = '0;
						push(KIND_TX, SYNC_BYTE, ST_NONE, 16'h0000);
						for (i = 3; i >= 0; i--)
							push_tx(rq.command_header[8*i +: 8]);
						push_tx({5'b00000, rq.data_length[10:8]});
						push_tx(rq.data_length[7:0]);
						tx_left = rq.data_length;
						if (rq.data_length == 0)
							close_command();
						else
							ph = PH_TXDATA;
					end
				end
				ACT_CMD_BYTE: begin
					if (ph == PH_TXDATA) begin
						push_tx(b);
						tx_left = tx_left - 11'd1;
						if (tx_left == 0)
							close_command();
					end
				end
				ACT_RX_BYTE: begin
					case (ph)
						PH_HUNT: begin
							if (b == SYNC_BYTE) begin
								ph = PH_HEAD;
								rx_cnt = 12'd1;
								lrc = '0;
							end
						end
						PH_HEAD: begin
							lrc ^= b;
							case (rx_cnt)
								12'd1: rsw = {b, 8'h00};
								12'd2: rsw = rsw | b;
								12'd3: rlen = {b, 8'h00};
								default: rlen = rlen | b;
							endcase
							rx_cnt = rx_cnt + 12'd1;
							if (rx_cnt >= 5) begin
								if (int'(rlen) + RX_OVERHEAD > RX_BYTES) begin
									push(KIND_STATUS, 8'h00, ST_OVERFLOW, 16'h0000);
									ph = PH_IDLE;
								end else if (rlen == 0) begin
									ph = PH_LRC;
								end else begin
									ph = PH_RXDATA;
								end
							end
						end
						PH_RXDATA: begin
							lrc ^= b;
							push(KIND_RX_DATA, b, ST_NONE, 16'h0000);
							rlen = rlen - 16'd1;
							if (rlen == 0)
								ph = PH_LRC;
						end
						PH_LRC: begin
							if (b != ~lrc)
								st = ST_LRC_ERR;
							else if (rsw == SW_SUCCESS)
								st = ST_OK;
							else
								st = ST_OTHER_SW;
							push(KIND_STATUS, 8'h00, st, rsw);
							ph = PH_IDLE;
						end
						default: ;
					endcase
				end
				default: begin
					if (ph == PH_HUNT) begin
						if (ticks_left != 0)
							ticks_left = ticks_left - 16'd1;
						if (ticks_left == 0) begin
							push(KIND_STATUS, 8'h00, ST_TIMEOUT, 16'h0000);
							ph = PH_IDLE;
						end
					end
				end
			endcase
			if (awaited.size() > n0) begin
				tail = awaited.pop_back();
				tail.last = 1'b1;
				awaited.push_back(tail);
			end
			return (awaited.size() > n0) || (was != {ph, tx_left, lrc, rx_cnt, rlen, rsw, ticks_left});
		endfunction

		function string show(frame_result_t r);
			return $sformatf("kind=%0d byte=%02h last=%0b status=%0d sw=%04h",
				r.kind, r.data, r.last, r.status, r.sw);
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			checked++;
			if (got.kind == KIND_STATUS)
				finals++;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: result with nothing awaited: %s", $time, show(got));
				return;
			end
			want = awaited.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: mismatch, expected %s, got %s", $time, show(want), show(got));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] action = '0;
	logic [31:0] command_header = '0;
	logic [10:0] data_length = '0;
	logic [7:0] byte_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic last;
	logic [2:0] status;
	logic [15:0] status_word;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;

	exchange_scoreboard sb = new();
	int tx_max_gap = 12;
	int rx_max_gap = 12;
	bit hold_request = 1'b0;
	int requests_accepted = 0;
	int effective_requests = 0;
	int quiet_cycles = 0;
	logic [15:0] last_timeout;

	apdu_frame_lrc_exchange_top #(
		.TX_BUFFER_BYTES(TX_BYTES),
		.RX_BUFFER_BYTES(RX_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.command_header(command_header),
		.data_length(data_length),
		.byte_value(byte_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.out_byte(out_byte),
		.last(last),
		.status(status),
		.status_word(status_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				sb.check_result({kind, out_byte, last, status, status_word});
				stall_left = $urandom_range(0, rx_max_gap);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic offer_request(input logic [1:0] act, input logic [31:0] hdr,
			input logic [10:0] len, input logic [7:0] b);
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		command_header <= hdr;
		data_length <= len;
		byte_value <= b;
		do @(posedge clk); while (in_stall);
		requests_accepted++;
		if (sb.note_request({act, hdr, len, b}))
			effective_requests++;
	endtask

	task automatic offer_start(input logic [31:0] hdr, input logic [10:0] len);
		offer_request(ACT_START, hdr, len, 8'($urandom));
	endtask

	task automatic offer_data(input logic [7:0] b);
		offer_request(ACT_CMD_BYTE, $urandom, 11'($urandom), b);
	endtask

	task automatic offer_rx(input logic [7:0] b);
		offer_request(ACT_RX_BYTE, $urandom, 11'($urandom), b);
	endtask

	task automatic offer_tick();
		offer_request(ACT_TICK, $urandom, 11'($urandom), 8'($urandom));
	endtask

	task automatic offer_stray();
		offer_request(2'($urandom_range(0, 3)), $urandom, 11'($urandom_range(0, 20)),
			8'($urandom));
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic write_reply_timeout(input logic [15:0] ticks);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= ticks;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.reply_timeout = ticks;
		last_timeout = ticks;
	endtask

	task automatic run_command(input logic [31:0] hdr, input logic [10:0] len);
		offer_start(hdr, len);
		while (sb.ph == PH_TXDATA) begin
			if ($urandom_range(0, 19) == 0)
				offer_stray();
			else
				offer_data(8'($urandom));
		end
	endtask

	task automatic run_reply();
		logic [15:0] sw;
		logic [15:0] rlen;
		logic [7:0] lrc;
		logic [7:0] b;
		int k;
		// sometimes let the hunt run out
		if ($urandom_range(0, 7) == 0) begin
			k = 0;
			while (sb.ph == PH_HUNT && k < 40) begin
				offer_tick();
				k++;
			end
		end
		repeat ($urandom_range(0, 3)) begin
			b = 8'($urandom);
			if (b == SYNC_BYTE)
				b = 8'h54;
			if ($urandom_range(0, 1))
				offer_rx(b);
			else
				offer_tick();
		end
		if (sb.ph != PH_HUNT)
			return;
		sw = $urandom_range(0, 1) ? SW_SUCCESS : 16'($urandom);
		k = $urandom_range(0, 19);
		if (k < 2)
			rlen = 16'($urandom) | 16'h0800;
		else if (k < 5)
			rlen = 16'd0;
		else if (k < 7)
			rlen = 16'($urandom_range(12, 40));
		else
			rlen = 16'($urandom_range(1, 6));
		lrc = sw[15:8] ^ sw[7:0] ^ rlen[15:8] ^ rlen[7:0];
		offer_rx(SYNC_BYTE);
		offer_rx(sw[15:8]);
		offer_rx(sw[7:0]);
		offer_rx(rlen[15:8]);
		offer_rx(rlen[7:0]);
		while (sb.ph == PH_RXDATA) begin
			if ($urandom_range(0, 19) == 0) begin
				offer_tick();
			end else begin
				b = 8'($urandom);
				lrc ^= b;
				offer_rx(b);
			end
		end
		if (sb.ph == PH_LRC)
			offer_rx(($urandom_range(0, 9) == 0) ? lrc ^ 8'($urandom_range(1, 255)) : ~lrc);
	endtask

	// drive whatever the block still waits for until it is idle again
	task automatic settle_idle();
		while (sb.ph != PH_IDLE) begin
			case (sb.ph)
				PH_TXDATA: offer_data(8'($urandom));
				PH_HUNT: offer_rx(SYNC_BYTE);
				PH_HEAD: offer_rx(8'h00);
				default: offer_rx(8'($urandom));
			endcase
		end
	endtask

	task automatic run_exchange();
		int pick;
		int span;
		pick = $urandom_range(0, 99);
		tx_max_gap = ($urandom_range(0, 4) == 0) ? 0 : 12;
		rx_max_gap = ($urandom_range(0, 4) == 0) ? 0 : 12;
		if (pick < 8) begin
			offer_start($urandom, 11'($urandom_range(2041, 2047)));
		end else if (pick < 13) begin
			offer_stray();
		end else begin
			span = $urandom_range(0, 9);
			if (span < 6)
				run_command($urandom, 11'($urandom_range(0, 4)));
			else if (span < 9)
				run_command($urandom, 11'($urandom_range(5, 16)));
			else
				run_command($urandom, 11'($urandom_range(17, 60)));
			run_reply();
		end
		settle_idle();
	endtask

	initial begin
		last_timeout = TIMEOUT_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_max_gap = 3;
		rx_max_gap = 3;
		// the first three do not reach the idle block; the start overflows
		offer_data(8'h3C);
		offer_rx(SYNC_BYTE);
		offer_tick();
		offer_start(32'h0000_0000, 11'd2047);
		// header only, all ones, exchange at the reset timeout
		offer_start(32'hFFFF_FFFF, 11'd0);
		offer_tick();
		offer_rx(8'h12);
		offer_rx(SYNC_BYTE);
		offer_rx(8'h90);
		offer_rx(8'h00);
		offer_rx(8'h00);
		offer_rx(8'h02);
		offer_rx(8'hFF);
		offer_rx(8'h00);
		offer_rx(~(8'h90 ^ 8'h02 ^ 8'hFF));
		wait_drain();
		write_reply_timeout(16'd2);

		// start while busy, then hunt times out
		offer_start(32'h00A4_0400, 11'd1);
		offer_start(32'h1234_5678, 11'd5);
		offer_data(8'hA5);
		offer_tick();
		offer_tick();
		offer_start(32'h8010_0000, 11'd2041);
		// reply length beyond the receive buffer
		offer_start(32'h8010_0000, 11'd0);
		offer_rx(SYNC_BYTE);
		offer_rx(8'h6A);
		offer_rx(8'h82);
		offer_rx(8'hFF);
		offer_rx(8'hFF);
		wait_drain();

		// hold the output long enough for the block to back up
		hold_request = 1'b1;
		tx_max_gap = 0;
		run_command($urandom, 11'd40);
		wait_drain();
		settle_idle();
		while (effective_requests < 130)
			run_exchange();

		wait_drain();
		write_reply_timeout(16'd0);
		while (effective_requests < 230)
			run_exchange();

		wait_drain();
		write_reply_timeout(16'hFFFF);
		while (effective_requests < 330)
			run_exchange();

		wait_drain();
		write_reply_timeout(16'($urandom_range(1, 10)));
		while (effective_requests < 430)
			run_exchange();

		wait_drain();
		$display("checked %0d results (%0d final statuses) from %0d requests, %0d with effect",
			sb.checked, sb.finals, requests_accepted, effective_requests);
		$display("reply timeout at 300, 2, 0, 65535 and %0d ticks; one long output hold-off",
			last_timeout);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
